@@ rtl/core/scat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector chain allocation table package
// Field widths, request codes and outcome codes shared by the block.
// ----------------------------------------------------------------------------
package scat_pkg;

   localparam int SECTOR_W   = 12;
   localparam int COUNT_W    = 13;
   localparam int ENTRY_W    = 13;
   localparam int RESERVED_W = 11;
   localparam int TOTAL_W    = 13;
   localparam int REQ_W      = 3;
   localparam int OUTCOME_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   // Largest sector count that the sector field can address.
   localparam int SECTOR_SPAN = 4096;

   typedef logic [REQ_W-1:0]     req_code_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

   localparam req_code_type REQ_ALLOCATE = 3'd0;
   localparam req_code_type REQ_DELETE   = 3'd1;
   localparam req_code_type REQ_RESTORE  = 3'd2;
   localparam req_code_type REQ_FREE     = 3'd3;
   localparam req_code_type REQ_QUERY    = 3'd4;

   localparam outcome_type OUT_OK          = 3'd0;
   localparam outcome_type OUT_NO_SPACE    = 3'd1;
   localparam outcome_type OUT_NOT_LIVE    = 3'd2;
   localparam outcome_type OUT_NOT_DELETED = 3'd3;
   localparam outcome_type OUT_BAD_SECTOR  = 3'd4;
   localparam outcome_type OUT_CHAIN_ERROR = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SECTORS  = 1'd1;

   localparam entry_type ENTRY_FREE     = 13'sd0;
   localparam entry_type ENTRY_END      = 13'sd1;
   localparam entry_type ENTRY_RESERVED = 13'sd2;
   localparam entry_type ENTRY_ROOT     = 13'sd3;

   localparam logic [RESERVED_W-1:0] RESERVED_RESET = 11'd32;
   localparam logic [TOTAL_W-1:0]    TOTAL_RESET    = 13'd4096;

endpackage

@@ rtl/core/sector_chain_allocation_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector chain allocation table
// Per-sector link table with first-fit chain allocation, soft delete, restore,
// free and entry query, driven by a small sequencer around one table memory.
// ----------------------------------------------------------------------------
// The block holds one request at a time and answers each with one response.
// After reset it clears the table one entry a cycle and stalls requests until
// that is done. An allocate scans the data area through the single read port
// at one entry a cycle, first to count free entries and, if enough are found,
// again to link them into a chain. Delete, restore and free walk the chain
// once to check it and, if it checks out, once more to rewrite it, one link a
// cycle. The response is held in an output register, so the next request is
// taken while it waits.
module sector_chain_allocation_table #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [scat_pkg::REQ_W-1:0]           req_type,
   input  logic [scat_pkg::SECTOR_W-1:0]        req_sector,
   input  logic [scat_pkg::COUNT_W-1:0]         req_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [scat_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic [scat_pkg::SECTOR_W-1:0]        rsp_first_sector,
   output logic signed [scat_pkg::ENTRY_W-1:0]  rsp_entry_value,
   input  logic                                 csr_we,
   input  logic [scat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scat_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int SW = scat_pkg::SECTOR_W;
   localparam int CW = scat_pkg::COUNT_W;
   localparam logic [CW-1:0] DATA_LIMIT =
      CW'((TABLE_ENTRIES > scat_pkg::SECTOR_SPAN) ? scat_pkg::SECTOR_SPAN : TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_SCAN1   = 4'd2;
   localparam logic [3:0] ST_SCAN2   = 4'd3;
   localparam logic [3:0] ST_TAIL    = 4'd4;
   localparam logic [3:0] ST_CHECK   = 4'd5;
   localparam logic [3:0] ST_REWRITE = 4'd6;
   localparam logic [3:0] ST_QUERY   = 4'd7;
   localparam logic [3:0] ST_RESP    = 4'd8;

   function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[AW-1:0];
   endfunction

   function automatic logic in_area(input logic [CW-1:0] x, input logic [CW-1:0] lo,
                                    input logic [CW-1:0] hi);
      return (x >= lo) && (x < hi);
   endfunction

   scat_pkg::entry_type link_mem [TABLE_ENTRIES];

   logic [3:0]                        state_ff, state_in;
   logic [AW-1:0]                     clr_ff, clr_in;
   logic [scat_pkg::RESERVED_W-1:0]   reserved_count_ff, reserved_count_in;
   logic [scat_pkg::TOTAL_W-1:0]      total_sectors_ff, total_sectors_in;
   logic [SW-1:0]                     walk_pointer_ff, walk_pointer_in;
   logic [CW-1:0]                     walk_steps_ff, walk_steps_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   scat_pkg::req_code_type            req_type_ff, req_type_in;
   logic [SW-1:0]                     sec_ff, sec_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     scan_ptr_ff, scan_ptr_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [SW-1:0]                     pend_sec_ff, pend_sec_in;
   logic [CW-1:0]                     found_ff, found_in;
   logic [SW-1:0]                     prev_ff, prev_in;
   logic                              have_prev_ff, have_prev_in;
   logic [SW-1:0]                     first_ff, first_in;
   scat_pkg::outcome_type             outcome_ff, outcome_in;
   scat_pkg::entry_type               entry_ff, entry_in;
   scat_pkg::outcome_type             rsp_outcome_ff;
   logic [SW-1:0]                     rsp_first_ff;
   scat_pkg::entry_type               rsp_entry_ff;
   scat_pkg::entry_type               mem_rd_ff;

   logic                              mem_we;
   logic [AW-1:0]                     mem_wa;
   logic [AW-1:0]                     mem_ra;
   scat_pkg::entry_type               mem_wd;
   logic                              rsp_load;

   logic [CW-1:0]                     data_start;
   logic [CW-1:0]                     data_end;
   logic [CW-1:0]                     data_count;
   logic [CW-1:0]                     req_sector_x;
   logic                              scan_more;
   logic                              scan_hit;
   logic [CW-1:0]                     found_nx;
   logic [CW-1:0]                     cur_m;
   logic [CW-1:0]                     steps_nx;
   logic                              bad_sign;
   scat_pkg::outcome_type             start_code;

   assign data_start   = {2'b00, reserved_count_ff} + CW'(2);
   assign data_end     = (total_sectors_ff > DATA_LIMIT) ? DATA_LIMIT : total_sectors_ff;
   assign data_count   = (data_end > data_start) ? (data_end - data_start) : '0;
   assign req_sector_x = {1'b0, req_sector};

   assign scan_more = scan_ptr_ff < data_end;
   assign scan_hit  = pend_valid_ff && (mem_rd_ff == scat_pkg::ENTRY_FREE);
   assign found_nx  = found_ff + CW'(scan_hit);
   assign cur_m     = mem_rd_ff[scat_pkg::ENTRY_W-1] ? CW'(-mem_rd_ff) : CW'(mem_rd_ff);
   assign steps_nx  = walk_steps_ff + CW'(1);

   always_comb begin
      unique case (req_type_ff) inside
         scat_pkg::REQ_DELETE: begin
            bad_sign   = mem_rd_ff[scat_pkg::ENTRY_W-1] || (mem_rd_ff == scat_pkg::ENTRY_FREE);
            start_code = scat_pkg::OUT_NOT_LIVE;
         end
         scat_pkg::REQ_RESTORE: begin
            bad_sign   = !mem_rd_ff[scat_pkg::ENTRY_W-1];
            start_code = scat_pkg::OUT_NOT_DELETED;
         end
         default: begin
            bad_sign   = mem_rd_ff == scat_pkg::ENTRY_FREE;
            start_code = scat_pkg::OUT_NOT_LIVE;
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      reserved_count_in = reserved_count_ff;
      total_sectors_in  = total_sectors_ff;
      walk_pointer_in   = walk_pointer_ff;
      walk_steps_in     = walk_steps_ff;
      req_type_in       = req_type_ff;
      sec_in            = sec_ff;
      count_in          = count_ff;
      scan_ptr_in       = scan_ptr_ff;
      pend_valid_in     = pend_valid_ff;
      pend_sec_in       = pend_sec_ff;
      found_in          = found_ff;
      prev_in           = prev_ff;
      have_prev_in      = have_prev_ff;
      first_in          = first_ff;
      outcome_in        = outcome_ff;
      entry_in          = entry_ff;
      mem_we            = 1'b0;
      mem_wa            = to_addr({1'b0, walk_pointer_ff});
      mem_wd            = scat_pkg::ENTRY_FREE;
      mem_ra            = to_addr(scan_ptr_ff);
      rsp_load          = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            scat_pkg::CSR_RESERVED_COUNT:
               reserved_count_in = csr_wdata[scat_pkg::RESERVED_W-1:0];
            scat_pkg::CSR_TOTAL_SECTORS:
               total_sectors_in = csr_wdata[scat_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = scat_pkg::ENTRY_FREE;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_type_in = req_type;
               sec_in      = req_sector;
               count_in    = req_count;
               first_in    = '0;
               entry_in    = scat_pkg::ENTRY_FREE;
               outcome_in  = scat_pkg::OUT_OK;
               state_in    = ST_RESP;
               unique case (req_type) inside
                  scat_pkg::REQ_ALLOCATE: begin
                     if (req_count == '0) begin
                        outcome_in = scat_pkg::OUT_NO_SPACE;
                     end else begin
                        scan_ptr_in   = data_start;
                        found_in      = '0;
                        pend_valid_in = 1'b0;
                        state_in      = ST_SCAN1;
                     end
                  end
                  scat_pkg::REQ_DELETE, scat_pkg::REQ_RESTORE, scat_pkg::REQ_FREE: begin
                     if (!in_area(req_sector_x, data_start, data_end)) begin
                        outcome_in = scat_pkg::OUT_BAD_SECTOR;
                     end else begin
                        mem_ra          = to_addr(req_sector_x);
                        walk_pointer_in = req_sector;
                        walk_steps_in   = '0;
                        state_in        = ST_CHECK;
                     end
                  end
                  scat_pkg::REQ_QUERY: begin
                     if (req_sector_x < {2'b00, reserved_count_ff}) begin
                        entry_in = scat_pkg::ENTRY_RESERVED;
                     end else if (req_sector_x < data_start) begin
                        entry_in = scat_pkg::ENTRY_ROOT;
                     end else if (req_sector_x < data_end) begin
                        mem_ra   = to_addr(req_sector_x);
                        state_in = ST_QUERY;
                     end else begin
                        outcome_in = scat_pkg::OUT_BAD_SECTOR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN1: begin
            mem_ra        = to_addr(scan_ptr_ff);
            pend_valid_in = scan_more;
            pend_sec_in   = scan_ptr_ff[SW-1:0];
            if (scan_more) begin
               scan_ptr_in = scan_ptr_ff + CW'(1);
            end
            found_in = found_nx;
            if (found_nx == count_ff) begin
               scan_ptr_in   = data_start;
               found_in      = '0;
               pend_valid_in = 1'b0;
               have_prev_in  = 1'b0;
               state_in      = ST_SCAN2;
            end else if (!pend_valid_ff && !scan_more) begin
               outcome_in = scat_pkg::OUT_NO_SPACE;
               state_in   = ST_RESP;
            end
         end
         ST_SCAN2: begin
            mem_ra        = to_addr(scan_ptr_ff);
            pend_valid_in = scan_more;
            pend_sec_in   = scan_ptr_ff[SW-1:0];
            if (scan_more) begin
               scan_ptr_in = scan_ptr_ff + CW'(1);
            end
            found_in = found_nx;
            if (scan_hit) begin
               if (have_prev_ff) begin
                  mem_we = 1'b1;
                  mem_wa = to_addr({1'b0, prev_ff});
                  mem_wd = scat_pkg::entry_type'({1'b0, pend_sec_ff});
               end else begin
                  first_in = pend_sec_ff;
               end
               prev_in      = pend_sec_ff;
               have_prev_in = 1'b1;
               if (found_nx == count_ff) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            mem_we   = 1'b1;
            mem_wa   = to_addr({1'b0, prev_ff});
            mem_wd   = scat_pkg::ENTRY_END;
            state_in = ST_RESP;
         end
         ST_CHECK: begin
            walk_steps_in = steps_nx;
            if (walk_steps_ff == '0 && bad_sign) begin
               outcome_in = start_code;
               state_in   = ST_RESP;
            end else if (steps_nx > data_count || bad_sign) begin
               outcome_in = scat_pkg::OUT_CHAIN_ERROR;
               state_in   = ST_RESP;
            end else if (cur_m == CW'(1)) begin
               mem_ra          = to_addr({1'b0, sec_ff});
               walk_pointer_in = sec_ff;
               walk_steps_in   = '0;
               state_in        = ST_REWRITE;
            end else if (!in_area(cur_m, data_start, data_end)) begin
               outcome_in = scat_pkg::OUT_CHAIN_ERROR;
               state_in   = ST_RESP;
            end else begin
               mem_ra          = to_addr(cur_m);
               walk_pointer_in = cur_m[SW-1:0];
            end
         end
         ST_REWRITE: begin
            mem_we        = 1'b1;
            mem_wa        = to_addr({1'b0, walk_pointer_ff});
            mem_wd        = (req_type_ff == scat_pkg::REQ_FREE) ? scat_pkg::ENTRY_FREE
                                                                : -mem_rd_ff;
            walk_steps_in = steps_nx;
            if (cur_m == CW'(1) || !in_area(cur_m, data_start, data_end) ||
                steps_nx >= data_count) begin
               state_in = ST_RESP;
            end else begin
               mem_ra          = to_addr(cur_m);
               walk_pointer_in = cur_m[SW-1:0];
            end
         end
         ST_QUERY: begin
            entry_in = mem_rd_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= link_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_ff            <= '0;
         reserved_count_ff <= scat_pkg::RESERVED_RESET;
         total_sectors_ff  <= scat_pkg::TOTAL_RESET;
         walk_pointer_ff   <= '0;
         walk_steps_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_ff            <= clr_in;
         reserved_count_ff <= reserved_count_in;
         total_sectors_ff  <= total_sectors_in;
         walk_pointer_ff   <= walk_pointer_in;
         walk_steps_ff     <= walk_steps_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      sec_ff        <= sec_in;
      count_ff      <= count_in;
      scan_ptr_ff   <= scan_ptr_in;
      pend_valid_ff <= pend_valid_in;
      pend_sec_ff   <= pend_sec_in;
      found_ff      <= found_in;
      prev_ff       <= prev_in;
      have_prev_ff  <= have_prev_in;
      first_ff      <= first_in;
      outcome_ff    <= outcome_in;
      entry_ff      <= entry_in;
      if (rsp_load) begin
         rsp_outcome_ff <= outcome_ff;
         rsp_first_ff   <= first_ff;
         rsp_entry_ff   <= entry_ff;
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_first_sector = rsp_first_ff;
   assign rsp_entry_value  = rsp_entry_ff;

endmodule
